// File: rtl/slis_pkg.sv
package slis_pkg;

    // Capacity of the sorted table.
    localparam int DEPTH     = 64;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);

    // Fixed payload widths of the channels.
    localparam int VAL_W     = 32;
    localparam int IDX_OUT_W = 6;
    localparam int CNT_OUT_W = 7;

    // Operation codes of an input item.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

endpackage

// File: rtl/slis_ram.sv
module slis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/sorted_list_insert_search_core.sv
// Sorted table of signed 32-bit values with insert and search.
// Input channel (i_in_valid / o_in_ready) carries i_op and i_value: an insert
// places the value before the first stored value that is greater or equal,
// a search looks for the first occurrence of the value. Every input transfer
// yields exactly one result transfer on the output channel (o_out_valid /
// i_out_ready) with o_found, o_index, o_count and o_full_res.
// One item is worked on at a time. The table lives in a RAM with one write
// and one registered read port, and the walk touches one entry per cycle.
// A search compares the entries from index 0 upward and stops at the first
// match, a miss compares all stored values. An insert walks from the top
// entry down, moving each larger or equal entry up by one, and then writes
// the value, also when it lands at index 0 (through the state S_PLACE).
// An insert into a full table or any item on an empty table needs no walk.
// The next item can be taken in the cycle after a result is loaded, so a new
// item is taken only once the result of the last one has been loaded.
// The result sits in an output register, so the next item is taken while it
// waits; when the receiver stalls and a second result is ready, the block
// holds it and takes no further item until the register frees.
// Reset empties the table at once (count returns to zero); no clearing pass.
module sorted_list_insert_search_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic                                   i_op,
    input  logic signed [slis_pkg::VAL_W-1:0]      i_value,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic                                   o_found,
    output logic        [slis_pkg::IDX_OUT_W-1:0]  o_index,
    output logic        [slis_pkg::CNT_OUT_W-1:0]  o_count,
    output logic                                   o_full_res
);

    localparam int AW = slis_pkg::ADDR_W;
    localparam int CW = slis_pkg::CNT_W;
    localparam int VW = slis_pkg::VAL_W;
    localparam int IW = slis_pkg::IDX_OUT_W;
    localparam int OW = slis_pkg::CNT_OUT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_INSERT,
        S_PLACE,
        S_DONE
    } t_state;

    t_state               r_state, n_state;
    logic [AW-1:0]        r_ptr, n_ptr;
    logic signed [VW-1:0] r_value, n_value;
    logic [CW-1:0]        r_count, n_count;
    logic                 r_res_found, n_res_found;
    logic [AW-1:0]        r_res_index, n_res_index;
    logic                 r_res_full, n_res_full;
    logic                 r_out_valid, n_out_valid;
    logic                 r_out_found, n_out_found;
    logic [AW-1:0]        r_out_index, n_out_index;
    logic [CW-1:0]        r_out_count, n_out_count;
    logic                 r_out_full, n_out_full;

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [VW-1:0]        wr_data;
    logic [AW-1:0]        rd_addr;
    logic [VW-1:0]        rd_data;
    logic [AW-1:0]        last_addr;

    slis_ram #(
        .WIDTH (VW),
        .DEPTH (slis_pkg::DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign last_addr = AW'(r_count - CW'(1));

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_value     = r_value;
        n_count     = r_count;
        n_res_found = r_res_found;
        n_res_index = r_res_index;
        n_res_full  = r_res_full;
        n_out_valid = r_out_valid;
        n_out_found = r_out_found;
        n_out_index = r_out_index;
        n_out_count = r_out_count;
        n_out_full  = r_out_full;
        wr_en       = 1'b0;
        wr_addr     = AW'(r_ptr + AW'(1));
        wr_data     = rd_data;
        rd_addr     = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                rd_addr = (i_op == slis_pkg::OP_SEARCH) ? '0 : last_addr;
                if (i_in_valid) begin
                    n_value     = i_value;
                    n_ptr       = rd_addr;
                    n_res_found = 1'b0;
                    n_res_index = '0;
                    n_res_full  = 1'b0;
                    if (i_op == slis_pkg::OP_SEARCH) begin
                        n_state = (r_count == '0) ? S_DONE : S_SEARCH;
                    end else if (r_count == CW'(slis_pkg::DEPTH)) begin
                        n_res_full = 1'b1;
                        n_state    = S_DONE;
                    end else if (r_count == '0) begin
                        wr_en   = 1'b1;
                        wr_addr = '0;
                        wr_data = i_value;
                        n_count = CW'(1);
                        n_state = S_DONE;
                    end else begin
                        n_state = S_INSERT;
                    end
                end
            end
            S_SEARCH: begin
                // The read for the following entry is issued while this one is compared.
                rd_addr = AW'(r_ptr + AW'(1));
                if ($signed(rd_data) == r_value) begin
                    n_res_found = 1'b1;
                    n_res_index = r_ptr;
                    n_state     = S_DONE;
                end else if (CW'(r_ptr) + CW'(1) == r_count) begin
                    n_state = S_DONE;
                end else begin
                    n_ptr = AW'(r_ptr + AW'(1));
                end
            end
            S_INSERT: begin
                // Walking down: entry r_ptr moves up to r_ptr + 1 while r_ptr - 1 is read.
                rd_addr = AW'(r_ptr - AW'(1));
                wr_en   = 1'b1;
                if ($signed(rd_data) >= r_value) begin
                    if (r_ptr == '0) begin
                        n_state = S_PLACE;
                    end else begin
                        n_ptr = AW'(r_ptr - AW'(1));
                    end
                end else begin
                    wr_data     = r_value;
                    n_res_index = AW'(r_ptr + AW'(1));
                    n_count     = CW'(r_count + CW'(1));
                    n_state     = S_DONE;
                end
            end
            S_PLACE: begin
                wr_en       = 1'b1;
                wr_addr     = '0;
                wr_data     = r_value;
                n_res_index = '0;
                n_count     = CW'(r_count + CW'(1));
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_res_found;
                    n_out_index = r_res_index;
                    n_out_count = r_count;
                    n_out_full  = r_res_full;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_ptr       <= n_ptr;
        r_value     <= n_value;
        r_res_found <= n_res_found;
        r_res_index <= n_res_index;
        r_res_full  <= n_res_full;
        r_out_found <= n_out_found;
        r_out_index <= n_out_index;
        r_out_count <= n_out_count;
        r_out_full  <= n_out_full;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_found     = r_out_found;
    assign o_index     = IW'(r_out_index);
    assign o_count     = OW'(r_out_count);
    assign o_full_res  = r_out_full;

endmodule

// File: rtl/slis_chk.sv
module slis_chk (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_in_valid,
    input logic                                   o_in_ready,
    input logic                                   i_op,
    input logic signed [slis_pkg::VAL_W-1:0]      i_value,
    input logic                                   o_out_valid,
    input logic                                   i_out_ready,
    input logic                                   o_found,
    input logic        [slis_pkg::IDX_OUT_W-1:0]  o_index,
    input logic        [slis_pkg::CNT_OUT_W-1:0]  o_count,
    input logic                                   o_full_res
);

    localparam int OW = slis_pkg::CNT_OUT_W;

    // A result offered to the receiver stays until its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result withdrawn before its transfer");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A dropped insert reports a full table and never a match.
    a_full_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_full_res |-> !o_found && o_count == OW'(slis_pkg::DEPTH))
        else $error("dropped insert with inconsistent fields");

    // A match needs at least one stored value.
    a_found_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_found |-> o_count != '0 && !o_full_res)
        else $error("match reported on an empty table");

endmodule

bind sorted_list_insert_search_core slis_chk u_slis_chk (.*);

// File: test/sorted_list_insert_search_core_test.sv
`timescale 1ns / 1ps

module sorted_list_insert_search_core_test;

    typedef struct {
        logic                              op;
        logic signed [slis_pkg::VAL_W-1:0] value;
    } t_table_op;

    typedef struct packed {
        logic                           found;
        logic [slis_pkg::IDX_OUT_W-1:0] index;
        logic [slis_pkg::CNT_OUT_W-1:0] count;
        logic                           full_res;
    } t_table_result;

    localparam int RANDOM_OPS    = 400;
    localparam int DRAIN_CYCLES  = 80;
    localparam int MAX_REPORTS   = 10;

    logic                              i_clk       = 1'b0;
    logic                              i_rst_n     = 1'b0;
    logic                              i_in_valid  = 1'b0;
    logic                              o_in_ready;
    logic                              i_op        = slis_pkg::OP_INSERT;
    logic signed [slis_pkg::VAL_W-1:0] i_value     = '0;
    logic                              o_out_valid;
    logic                              i_out_ready = 1'b0;
    logic                              o_found;
    logic [slis_pkg::IDX_OUT_W-1:0]    o_index;
    logic [slis_pkg::CNT_OUT_W-1:0]    o_count;
    logic                              o_full_res;

    t_table_op                         pending_ops[$];
    t_table_result                     expected_results[$];
    logic signed [slis_pkg::VAL_W-1:0] inserted_vals[$];

    // Shadow of the sorted table, updated as items are taken by the block.
    logic signed [slis_pkg::VAL_W-1:0] model_table [slis_pkg::DEPTH];
    int                                model_count = 0;

    int total_ops      = 0;
    int ops_sent       = 0;
    int ops_accepted   = 0;
    int mismatch_cnt   = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit in_taken       = 1'b0;

    sorted_list_insert_search_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_found     (o_found),
        .o_index     (o_index),
        .o_count     (o_count),
        .o_full_res  (o_full_res)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_table_result predict_table_result(
        input logic                              op,
        input logic signed [slis_pkg::VAL_W-1:0] value
    );
        t_table_result res;
        int            pos;
        res = '0;
        if (op == slis_pkg::OP_INSERT) begin
            if (model_count >= slis_pkg::DEPTH) begin
                res.full_res = 1'b1;
            end else begin
                // A new value goes in front of any equal values already stored.
                pos = 0;
                while (pos < model_count && model_table[pos] < value) pos++;
                for (int k = model_count; k > pos; k--) model_table[k] = model_table[k - 1];
                model_table[pos] = value;
                model_count++;
                res.index = slis_pkg::IDX_OUT_W'(pos);
            end
        end else begin
            for (int k = model_count - 1; k >= 0; k--) begin
                if (model_table[k] == value) begin
                    res.found = 1'b1;
                    res.index = slis_pkg::IDX_OUT_W'(k);
                end
            end
        end
        res.count = slis_pkg::CNT_OUT_W'(model_count);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS) $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    task automatic add_op(input logic op, input logic signed [slis_pkg::VAL_W-1:0] value);
        t_table_op item;
        item.op    = op;
        item.value = value;
        pending_ops.push_back(item);
        if (op == slis_pkg::OP_INSERT && inserted_vals.size() < slis_pkg::DEPTH)
            inserted_vals.push_back(value);
    endtask

    function automatic logic signed [slis_pkg::VAL_W-1:0] pick_insert_value();
        int sel;
        sel = $urandom_range(5);
        case (sel)
            0, 1: begin
                return $signed($urandom_range(16)) - 8;
            end
            2: begin
                case ($urandom_range(3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh8000_0001;
                    2: return 32'sh7FFF_FFFE;
                    default: return 32'sh7FFF_FFFF;
                endcase
            end
            default: begin
                return $signed($urandom);
            end
        endcase
    endfunction

    function automatic logic signed [slis_pkg::VAL_W-1:0] pick_search_value();
        int                                sel;
        logic signed [slis_pkg::VAL_W-1:0] hit;
        sel = $urandom_range(9);
        if (inserted_vals.size() == 0 || sel >= 7) begin
            return (sel[0]) ? $signed($urandom) : $signed($urandom_range(16)) - 8;
        end
        hit = inserted_vals[$urandom_range(inserted_vals.size() - 1)];
        if (sel == 5) return hit + 1;
        if (sel == 6) return hit - 1;
        return hit;
    endfunction

    // Input driver: one new item per free slot, with random idle cycles.
    always @(negedge i_clk) begin : drive_inputs
        t_table_op item;
        int        phase;
        if (i_rst_n) begin
            phase = (total_ops > 0) ? (ops_sent * 3) / total_ops : 2;
            send_idle_pct  = (phase == 0) ? 9 : (phase == 1) ? 57 : 0;
            recv_stall_pct = (phase == 0) ? 57 : (phase == 1) ? 9 : 0;
            if (!i_in_valid || in_taken) begin
                if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    item = pending_ops.pop_front();
                    ops_sent++;
                    i_in_valid <= 1'b1;
                    i_op       <= item.op;
                    i_value    <= item.value;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: predicts on every input transfer and checks every result transfer.
    always @(posedge i_clk) begin : watch_transfers
        t_table_result got;
        t_table_result want;
        in_taken = i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.found    = o_found;
            got.index    = o_index;
            got.count    = o_count;
            got.full_res = o_full_res;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf(
                    "unexpected result found=%b index=%0d count=%0d full=%b",
                    got.found, got.index, got.count, got.full_res));
            end else begin
                want = expected_results.pop_front();
                if (got.found !== want.found || got.index !== want.index ||
                    got.count !== want.count || got.full_res !== want.full_res) begin
                    report_mismatch($sformatf(
                        {"expected found=%b index=%0d count=%0d full=%b, ",
                         "got found=%b index=%0d count=%0d full=%b"},
                        want.found, want.index, want.count, want.full_res,
                        got.found, got.index, got.count, got.full_res));
                end
            end
        end
        if (in_taken) begin
            expected_results.push_back(predict_table_result(i_op, i_value));
            ops_accepted++;
        end
    end

    initial begin : run_test
        logic op;
        int   inserts;

        // Directed part: empty table, extremes, duplicates and misses.
        add_op(slis_pkg::OP_SEARCH, 32'sd0);
        add_op(slis_pkg::OP_INSERT, 32'sd0);
        add_op(slis_pkg::OP_INSERT, 32'sh7FFF_FFFF);
        add_op(slis_pkg::OP_INSERT, 32'sh8000_0000);
        add_op(slis_pkg::OP_INSERT, 32'sd0);
        add_op(slis_pkg::OP_INSERT, -32'sd1);
        add_op(slis_pkg::OP_INSERT, 32'sd1);
        add_op(slis_pkg::OP_SEARCH, 32'sd0);
        add_op(slis_pkg::OP_SEARCH, 32'sh8000_0000);
        add_op(slis_pkg::OP_SEARCH, 32'sh7FFF_FFFF);
        add_op(slis_pkg::OP_SEARCH, 32'sd5);
        add_op(slis_pkg::OP_SEARCH, 32'sh8000_0001);
        add_op(slis_pkg::OP_INSERT, 32'sh7FFF_FFFF);
        add_op(slis_pkg::OP_SEARCH, 32'sh7FFF_FFFF);
        add_op(slis_pkg::OP_INSERT, 32'sh5555_5555);
        add_op(slis_pkg::OP_INSERT, 32'shAAAA_AAAA);
        add_op(slis_pkg::OP_SEARCH, 32'sh5555_5555);
        add_op(slis_pkg::OP_SEARCH, 32'shAAAA_AAAA);
        add_op(slis_pkg::OP_SEARCH, -32'sd1);
        add_op(slis_pkg::OP_SEARCH, 32'sh7FFF_FFFE);

        // Random part: fill the table with a mix of inserts and searches, then
        // keep searching and pushing inserts into the full table.
        for (int n = 0; n < RANDOM_OPS; n++) begin
            inserts = inserted_vals.size();
            if (inserts < slis_pkg::DEPTH && RANDOM_OPS - n <= slis_pkg::DEPTH - inserts)
                op = slis_pkg::OP_INSERT;
            else if (inserts < slis_pkg::DEPTH)
                op = ($urandom_range(99) < 50) ? slis_pkg::OP_INSERT : slis_pkg::OP_SEARCH;
            else
                op = ($urandom_range(99) < 25) ? slis_pkg::OP_INSERT : slis_pkg::OP_SEARCH;
            add_op(op, (op == slis_pkg::OP_INSERT) ? pick_insert_value() : pick_search_value());
        end
        total_ops = pending_ops.size();

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (ops_accepted < total_ops || expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

        if (mismatch_cnt == 0) begin
            $display("sorted_list_insert_search_core_test OK");
        end else begin
            $display("sorted_list_insert_search_core_test NOT OK");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("sorted_list_insert_search_core_test NOT OK");
        $finish;
    end

endmodule
